// ===== hw/rtl/clnsd_pkg.sv =====
// Shared types, constants and helper functions of the cell list neighbour search.
// Used by clnsd_ctrl, clnsd_dp and the top level; depends on nothing.
package clnsd_pkg;

	localparam int MAX_PARTICLES      = 64;
	localparam int MAX_CELLS_PER_SIDE = 16;
	localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
	localparam int IDX_W   = $clog2(MAX_PARTICLES);
	localparam int POS_W   = 16;
	localparam int CELL_W  = $clog2(MAX_CELLS_PER_SIDE);
	localparam int HEAD_AW = 3 * CELL_W;
	localparam int SIDE_W  = 5;
	localparam int DIST_W  = 34;
	localparam int SQ_W    = 2 * POS_W;
	localparam logic [POS_W:0] HALF_BOX = 17'h08000;
	localparam logic [POS_W:0] BOX      = 17'h10000;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_CLEAR = 2'd0;
	localparam mode_t MODE_LOAD  = 2'd1;
	localparam mode_t MODE_QUERY = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_NEIGH = 2'd0;
	localparam status_t ST_DONE  = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_MISS  = 2'd3;

	// APB register slots, taken from paddr[4:3]
	typedef logic [1:0] reg_sel_t;
	localparam reg_sel_t REG_CELLS   = 2'd0;
	localparam reg_sel_t REG_CUTOFF  = 2'd1;
	localparam reg_sel_t REG_PERIODIC = 2'd2;

	typedef struct packed {
		logic [1:0]        n;
		logic [CELL_W-1:0] l0;
		logic [CELL_W-1:0] l1;
		logic [CELL_W-1:0] l2;
	} axis_list_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       sweep;
		logic       cnt_clr;
		logic       head_rd_load;
		logic       head_rd_cell;
		logic       load_wr;
		logic       q_pos_rd;
		logic       q_setup;
		logic       head_take;
		logic       cell_adv;
		logic       part_rd;
		logic       sq_en;
		logic [1:0] sq_axis;
		logic       acc_ld;
		logic       acc_add;
		logic       cmp_step;
		logic       emit_resp;
		logic       emit_load;
		logic       emit_fin;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  q_bad;
		logic  sweep_last;
		logic  head_zero;
		logic  next_zero;
		logic  last_cell;
		logic  hit;
		logic  pend_v;
		logic  out_free;
	} stat_t;

	function automatic logic [CELL_W-1:0] bin_of(input logic [POS_W-1:0] pos,
			input logic [SIDE_W-1:0] side);
		logic [POS_W+SIDE_W-1:0] p;
		p = {{SIDE_W{1'b0}}, pos} * {{POS_W{1'b0}}, side};
		return p[POS_W+CELL_W-1:POS_W];
	endfunction

	// Own cell first, then next, previous; edges put previous first, drop or wrap
	function automatic axis_list_t axis_cells(input logic [CELL_W-1:0] c,
			input logic [SIDE_W-1:0] side, input logic per);
		axis_list_t r;
		logic [CELL_W-1:0] sm1;
		sm1  = CELL_W'(side - 5'd1);
		r.n  = 2'd1;
		r.l0 = c;
		r.l1 = '0;
		r.l2 = '0;
		if (side == 5'd2) begin
			r.n  = 2'd2;
			r.l1 = {{(CELL_W-1){1'b0}}, ~c[0]};
		end else if (side > 5'd2) begin
			if (c == '0) begin
				if (per) begin
					r.n  = 2'd3;
					r.l1 = sm1;
					r.l2 = CELL_W'(1);
				end else begin
					r.n  = 2'd2;
					r.l1 = CELL_W'(1);
				end
			end else if (c == sm1) begin
				r.l1 = c - CELL_W'(1);
				r.n  = per ? 2'd3 : 2'd2;
				r.l2 = '0;
			end else begin
				r.n  = 2'd3;
				r.l1 = c + CELL_W'(1);
				r.l2 = c - CELL_W'(1);
			end
		end
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] pick(input axis_list_t l, input logic [1:0] i);
		logic [CELL_W-1:0] r;
		case (i)
			2'd0:    r = l.l0;
			2'd1:    r = l.l1;
			default: r = l.l2;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/clnsd_ctrl.sv =====
// Controller state machine of the neighbour search: sequences clear sweeps,
// loads and query walks. Depends on clnsd_pkg.
module clnsd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  clnsd_pkg::stat_t st,
	output clnsd_pkg::cmd_t  cmd
);
	import clnsd_pkg::*;

	typedef enum logic [17:0] {
		S_INIT = 18'h00001, S_IDLE = 18'h00002, S_DEC  = 18'h00004,
		S_CLR  = 18'h00008, S_RESP = 18'h00010, S_LRD  = 18'h00020,
		S_LWR  = 18'h00040, S_QPOS = 18'h00080, S_QSET = 18'h00100,
		S_CELL = 18'h00200, S_HEAD = 18'h00400, S_PRD  = 18'h00800,
		S_D0   = 18'h01000, S_D1   = 18'h02000, S_D2   = 18'h04000,
		S_D3   = 18'h08000, S_CMP  = 18'h10000, S_FIN  = 18'h20000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else         state_q <= state_d;
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (st.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.capture = s_tvalid;
				if (s_tvalid) state_d = S_DEC;
			end
			S_DEC: begin
				case (st.mode)
					MODE_CLEAR: state_d = S_CLR;
					MODE_LOAD:  state_d = st.full ? S_RESP : S_LRD;
					MODE_QUERY: state_d = st.q_bad ? S_RESP : S_QPOS;
					default:    state_d = S_RESP;
				endcase
			end
			S_CLR: begin
				cmd.sweep   = 1'b1;
				cmd.cnt_clr = 1'b1;
				if (st.sweep_last) state_d = S_RESP;
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.emit_resp = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_LRD: begin
				cmd.head_rd_load = 1'b1;
				state_d          = S_LWR;
			end
			S_LWR: begin
				if (st.out_free) begin
					cmd.load_wr   = 1'b1;
					cmd.emit_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_QPOS: begin
				cmd.q_pos_rd = 1'b1;
				state_d      = S_QSET;
			end
			S_QSET: begin
				cmd.q_setup = 1'b1;
				state_d     = S_CELL;
			end
			S_CELL: begin
				cmd.head_rd_cell = 1'b1;
				state_d          = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_take = 1'b1;
				if (!st.head_zero) begin
					state_d = S_PRD;
				end else if (st.last_cell) begin
					state_d = S_FIN;
				end else begin
					cmd.cell_adv = 1'b1;
					state_d      = S_CELL;
				end
			end
			S_PRD: begin
				cmd.part_rd = 1'b1;
				state_d     = S_D0;
			end
			S_D0: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = 2'd0;
				state_d     = S_D1;
			end
			S_D1: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = 2'd1;
				cmd.acc_ld  = 1'b1;
				state_d     = S_D2;
			end
			S_D2: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = 2'd2;
				cmd.acc_add = 1'b1;
				state_d     = S_D3;
			end
			S_D3: begin
				cmd.acc_add = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				if (!(st.hit && st.pend_v && !st.out_free)) begin
					cmd.cmp_step = 1'b1;
					if (!st.next_zero) begin
						state_d = S_PRD;
					end else if (st.last_cell) begin
						state_d = S_FIN;
					end else begin
						cmd.cell_adv = 1'b1;
						state_d      = S_CELL;
					end
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.emit_fin = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/clnsd_dp.sv =====
// Datapath of the neighbour search: cell head, link and position memories,
// cell walk counters, distance unit and result register. Depends on clnsd_pkg.
module clnsd_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  clnsd_pkg::cmd_t                      cmd,
	output clnsd_pkg::stat_t                     st,
	input  logic [1:0]                           s_tuser,
	input  logic [55:0]                          s_tdata,
	input  logic [clnsd_pkg::SIDE_W-1:0]         side,
	input  logic [clnsd_pkg::DIST_W-1:0]         cutoff_sq,
	input  logic                                 periodic,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [39:0]                          m_tdata,
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast
);
	import clnsd_pkg::*;

	localparam int PW = 3 * POS_W;

	logic [CNT_W:0] unused_guard;

	logic [CNT_W-1:0] head_mem [2**HEAD_AW];
	logic [CNT_W-1:0] next_mem [MAX_PARTICLES];
	logic [PW-1:0]    pos_mem  [MAX_PARTICLES];

	mode_t             mode_q;
	logic [IDX_W-1:0]  q_q;
	logic [PW-1:0]     ipos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HEAD_AW-1:0] sweep_q;
	logic [CNT_W-1:0]  head_rd_q;
	logic [CNT_W-1:0]  next_rd_q;
	logic [PW-1:0]     pos_rd_q;
	logic [PW-1:0]     qpos_q;
	axis_list_t        lx_q, ly_q, lz_q;
	logic [1:0]        ix_q, iy_q, iz_q;
	logic [CNT_W-1:0]  cur_q;
	logic [SQ_W-1:0]   sq_s1;
	logic [DIST_W-1:0] acc_q;
	logic              pend_v_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic [DIST_W-1:0] pend_dist_q;
	logic              m_valid_q;
	logic [39:0]       m_data_q;
	logic [1:0]        m_user_q;
	logic              m_last_q;

	logic [HEAD_AW-1:0] load_addr, cell_addr, head_raddr, head_waddr;
	logic [CNT_W-1:0]   head_wdata;
	logic               head_we;
	logic [IDX_W-1:0]   pos_raddr, cur_idx;
	logic               last_x, last_y, last_z;
	logic [POS_W-1:0]   ga, gb, gap, gap_w;
	logic [POS_W:0]     wrap;
	logic               out_free;

	assign unused_guard = '0;

	assign load_addr = {bin_of(ipos_q[POS_W-1:0], side),
		bin_of(ipos_q[2*POS_W-1:POS_W], side), bin_of(ipos_q[PW-1:2*POS_W], side)};
	assign cell_addr = {pick(lx_q, ix_q), pick(ly_q, iy_q), pick(lz_q, iz_q)};
	assign head_raddr = cmd.head_rd_load ? load_addr : cell_addr;
	assign head_we    = cmd.sweep || cmd.load_wr;
	assign head_waddr = cmd.sweep ? sweep_q : load_addr;
	assign head_wdata = cmd.sweep ? '0 : cnt_q + CNT_W'(1);
	assign cur_idx    = IDX_W'(cur_q - CNT_W'(1));
	assign pos_raddr  = cmd.q_pos_rd ? q_q : cur_idx;

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		if (cmd.head_rd_load || cmd.head_rd_cell) head_rd_q <= head_mem[head_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			pos_mem[cnt_q[IDX_W-1:0]]  <= ipos_q;
			next_mem[cnt_q[IDX_W-1:0]] <= head_rd_q;
		end
		if (cmd.q_pos_rd || cmd.part_rd) pos_rd_q <= pos_mem[pos_raddr];
		if (cmd.part_rd) next_rd_q <= next_mem[cur_idx];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sweep_q   <= '0;
			pend_v_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep) sweep_q <= sweep_q + HEAD_AW'(1);
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.load_wr) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.q_setup || cmd.emit_fin) pend_v_q <= 1'b0;
			else if (cmd.cmp_step && st.hit) pend_v_q <= 1'b1;
			if (cmd.emit_resp || cmd.emit_load || cmd.emit_fin ||
					(cmd.cmp_step && st.hit && pend_v_q)) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// Walk, distance and result payload
	always_comb begin
		case (cmd.sq_axis)
			2'd0: begin
				ga = pos_rd_q[POS_W-1:0];
				gb = qpos_q[POS_W-1:0];
			end
			2'd1: begin
				ga = pos_rd_q[2*POS_W-1:POS_W];
				gb = qpos_q[2*POS_W-1:POS_W];
			end
			default: begin
				ga = pos_rd_q[PW-1:2*POS_W];
				gb = qpos_q[PW-1:2*POS_W];
			end
		endcase
		gap   = (ga > gb) ? ga - gb : gb - ga;
		wrap  = BOX - {1'b0, gap};
		gap_w = (periodic && ({1'b0, gap} > HALF_BOX)) ? wrap[POS_W-1:0] : gap;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= s_tuser;
			q_q    <= s_tdata[IDX_W-1:0];
			ipos_q <= s_tdata[IDX_W+PW-1:IDX_W];
		end
		if (cmd.q_setup) begin
			qpos_q <= pos_rd_q;
			lx_q   <= axis_cells(bin_of(pos_rd_q[POS_W-1:0], side), side, periodic);
			ly_q   <= axis_cells(bin_of(pos_rd_q[2*POS_W-1:POS_W], side), side, periodic);
			lz_q   <= axis_cells(bin_of(pos_rd_q[PW-1:2*POS_W], side), side, periodic);
			ix_q   <= '0;
			iy_q   <= '0;
			iz_q   <= '0;
		end else if (cmd.cell_adv) begin
			if (!last_z) begin
				iz_q <= iz_q + 2'd1;
			end else begin
				iz_q <= '0;
				if (!last_y) begin
					iy_q <= iy_q + 2'd1;
				end else begin
					iy_q <= '0;
					ix_q <= ix_q + 2'd1;
				end
			end
		end
		if (cmd.head_take) cur_q <= head_rd_q;
		else if (cmd.cmp_step) cur_q <= next_rd_q;
		if (cmd.sq_en) sq_s1 <= {{POS_W{1'b0}}, gap_w} * {{POS_W{1'b0}}, gap_w};
		if (cmd.acc_ld) acc_q <= {2'b0, sq_s1};
		else if (cmd.acc_add) acc_q <= acc_q + {2'b0, sq_s1};
		if (cmd.cmp_step && st.hit) begin
			pend_idx_q  <= cur_idx;
			pend_dist_q <= acc_q;
		end
		if (cmd.emit_resp) begin
			m_last_q <= 1'b1;
			case (mode_q)
				MODE_LOAD: begin
					m_user_q <= ST_FULL;
					m_data_q <= '0;
				end
				MODE_QUERY: begin
					m_user_q <= ST_MISS;
					m_data_q <= {34'b0, q_q};
				end
				default: begin
					m_user_q <= ST_DONE;
					m_data_q <= '0;
				end
			endcase
		end else if (cmd.emit_load) begin
			m_last_q <= 1'b1;
			m_user_q <= ST_DONE;
			m_data_q <= {34'b0, cnt_q[IDX_W-1:0]};
		end else if (cmd.emit_fin) begin
			m_last_q <= 1'b1;
			m_user_q <= pend_v_q ? ST_NEIGH : ST_DONE;
			m_data_q <= pend_v_q ? {pend_dist_q, pend_idx_q} : '0;
		end else if (cmd.cmp_step && st.hit && pend_v_q) begin
			m_last_q <= 1'b0;
			m_user_q <= ST_NEIGH;
			m_data_q <= {pend_dist_q, pend_idx_q};
		end
	end

	assign last_x   = (ix_q == lx_q.n - 2'd1);
	assign last_y   = (iy_q == ly_q.n - 2'd1);
	assign last_z   = (iz_q == lz_q.n - 2'd1);
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		st            = '0;
		st.mode       = mode_q;
		st.full       = (cnt_q >= CNT_W'(MAX_PARTICLES)) || (unused_guard != '0);
		st.q_bad      = ({1'b0, q_q} >= cnt_q);
		st.sweep_last = &sweep_q;
		st.head_zero  = (head_rd_q == '0);
		st.next_zero  = (next_rd_q == '0);
		st.last_cell  = last_x && last_y && last_z;
		st.hit        = (acc_q < cutoff_sq);
		st.pend_v     = pend_v_q;
		st.out_free   = out_free;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== hw/rtl/cell_list_neighbour_search_3d_unit.sv =====
// Top level of the 3D cell list neighbour search: APB registers, controller
// and datapath. Depends on clnsd_pkg, clnsd_ctrl and clnsd_dp.
// A clear sweeps every cell head; a query walks every listed cell and each particle
// linked in it (one read per memory per cycle). Output stalls hold the block; it takes
// one item at a time.
// Reset: registers to defaults, then a sweep empties the cell heads.
module cell_list_neighbour_search_3d_unit (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // query_index[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // found_index[5:0], dist_sq[39:6]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);
	import clnsd_pkg::*;

	logic [SIDE_W-1:0] cells_q;
	logic [DIST_W-1:0] cutoff_q;
	logic              periodic_q;
	logic [SIDE_W-1:0] side;
	reg_sel_t          sel;
	logic              wr_en;
	cmd_t              cmd;
	stat_t             st;

	assign pready = 1'b1;
	assign sel    = paddr[4:3];
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes land on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q    <= SIDE_W'(1);
			cutoff_q   <= '0;
			periodic_q <= 1'b0;
		end else if (wr_en) begin
			unique case (sel)
				REG_CELLS:    cells_q    <= pwdata[SIDE_W-1:0];
				REG_CUTOFF:   cutoff_q   <= pwdata[DIST_W-1:0];
				REG_PERIODIC: periodic_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_CELLS:    prdata = {{(64-SIDE_W){1'b0}}, cells_q};
			REG_CUTOFF:   prdata = {{(64-DIST_W){1'b0}}, cutoff_q};
			REG_PERIODIC: prdata = {63'b0, periodic_q};
			default:      prdata = '0;
		endcase
	end

	// Clamp the cell count: zero counts as one, above the maximum as the maximum
	always_comb begin
		if (cells_q == '0) side = SIDE_W'(1);
		else if (cells_q > SIDE_W'(MAX_CELLS_PER_SIDE)) side = SIDE_W'(MAX_CELLS_PER_SIDE);
		else side = cells_q;
	end

	clnsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	clnsd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.side      (side),
		.cutoff_sq (cutoff_q),
		.periodic  (periodic_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// One item at a time: accepting drops ready in the following cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in flight");

	// Only neighbour reports may be followed by further results of the same item
	a_nonneigh_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_NEIGH) |-> m_tlast)
		else $error("non-neighbour result without last");

	// Non-neighbour results carry no distance
	a_nonneigh_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_NEIGH) |-> (m_tdata[39:6] == '0))
		else $error("distance set on non-neighbour result");

endmodule

// ===== verif/cell_list_neighbour_search_3d_unit_tb.sv =====
// Self-checking testbench of the 3D cell list neighbour search unit.
// Drives clear, load and query items over the stream port, predicts every result
// in place and compares field by field. Depends on clnsd_pkg and the top level.
module cell_list_neighbour_search_3d_unit_tb;
	import clnsd_pkg::*;

	localparam mode_t MODE_BAD = 2'd3;

	typedef struct packed {
		mode_t      mode;
		logic [5:0] qidx;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
	} cmd_item_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  idx;
		logic [33:0] sq_dist;
		logic        last;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	cell_list_neighbour_search_3d_unit dut (.*);

	// predictor state, mirrors the block's store
	logic [4:0]  side_reg;
	logic [33:0] cut_reg;
	logic        wrap_reg;
	logic [6:0]  heads[4096];
	logic [6:0]  links[64];
	logic [15:0] store_pos[64][3];
	int          n_stored;

	cmd_item_t pending_items[$];
	answer_t   expected_answers[$];

	int  send_idle_pct, recv_idle_pct;
	bit  hold_recv;
	bit  taken;
	int  hold_left;
	int  errors, n_sent, n_got, n_queries, n_hits;
	int  quiet_cycles;

	localparam int WATCHDOG = 40000;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_side();
		int s;
		s = side_reg;
		if (s < 1) s = 1;
		if (s > MAX_CELLS_PER_SIDE) s = MAX_CELLS_PER_SIDE;
		return s;
	endfunction

	function automatic int bin_pos(logic [15:0] p, int s);
		return (int'(p) * s) >> 16;
	endfunction

	function automatic int head_addr(int cx, int cy, int cz);
		return ((cx * 16 + cy) * 16 + cz) & 4095;
	endfunction

	// neighbour cells along one axis, own cell first
	function automatic int near_cells(int c, int s, output int l[3]);
		int n;
		l = '{0, 0, 0};
		n = 0;
		l[n++] = c;
		if (s == 1) return n;
		if (s == 2) begin
			l[n++] = 1 - (c & 1);
			return n;
		end
		if (c == 0) begin
			if (wrap_reg) l[n++] = s - 1;
			l[n++] = 1;
		end else if (c == s - 1) begin
			l[n++] = c - 1;
			if (wrap_reg) l[n++] = 0;
		end else begin
			l[n++] = c + 1;
			l[n++] = c - 1;
		end
		return n;
	endfunction

	function automatic logic [33:0] image_dist(int a, int b);
		logic [33:0] sum;
		int g;
		sum = '0;
		for (int d = 0; d < 3; d++) begin
			g = int'(store_pos[a][d]) - int'(store_pos[b][d]);
			if (g < 0) g = -g;
			if (wrap_reg && g > 32768) g = 65536 - g;
			sum += 34'(longint'(g) * longint'(g));
		end
		return sum;
	endfunction

	function automatic answer_t mk(status_t st, int idx, logic [33:0] d, logic l);
		answer_t r;
		r.status = st;
		r.idx = 6'(idx);
		r.sq_dist = d;
		r.last = l;
		return r;
	endfunction

	function automatic void expect_answer(answer_t a);
		expected_answers = {expected_answers, a};
	endfunction

	// work out the results of one accepted item and queue them
	task automatic predict_results(cmd_item_t it);
		int s, q, k, cur, guard, j, a;
		int lx[3], ly[3], lz[3];
		int nx, ny, nz;
		logic [33:0] dd;
		answer_t hits[$];
		s = eff_side();
		case (it.mode)
			MODE_CLEAR: begin
				foreach (heads[i]) heads[i] = '0;
				n_stored = 0;
				expect_answer(mk(ST_DONE, 0, '0, 1'b1));
			end
			MODE_LOAD: begin
				if (n_stored >= MAX_PARTICLES) begin
					expect_answer(mk(ST_FULL, 0, '0, 1'b1));
				end else begin
					store_pos[n_stored][0] = it.px;
					store_pos[n_stored][1] = it.py;
					store_pos[n_stored][2] = it.pz;
					a = head_addr(bin_pos(it.px, s), bin_pos(it.py, s), bin_pos(it.pz, s));
					links[n_stored] = heads[a];
					heads[a] = 7'(n_stored + 1);
					expect_answer(mk(ST_DONE, n_stored, '0, 1'b1));
					n_stored++;
				end
			end
			MODE_QUERY: begin
				q = it.qidx;
				n_queries++;
				if (q >= n_stored) begin
					expect_answer(mk(ST_MISS, q, '0, 1'b1));
				end else begin
					nx = near_cells(bin_pos(store_pos[q][0], s), s, lx);
					ny = near_cells(bin_pos(store_pos[q][1], s), s, ly);
					nz = near_cells(bin_pos(store_pos[q][2], s), s, lz);
					k = 0;
					for (int ix = 0; ix < nx; ix++)
						for (int iy = 0; iy < ny; iy++)
							for (int iz = 0; iz < nz; iz++) begin
								cur = heads[head_addr(lx[ix], ly[iy], lz[iz])];
								guard = 0;
								while (cur != 0 && guard < 64 && k < 64) begin
									j = cur - 1;
									dd = image_dist(q, j);
									if (dd < cut_reg) begin
										hits = {hits, mk(ST_NEIGH, j, dd, 1'b0)};
										k++;
									end
									cur = links[j];
									guard++;
								end
							end
					if (k == 0) begin
						expect_answer(mk(ST_DONE, 0, '0, 1'b1));
					end else begin
						hits[k-1].last = 1'b1;
						n_hits += k;
						foreach (hits[i]) expect_answer(hits[i]);
					end
				end
			end
			default: expect_answer(mk(ST_DONE, 0, '0, 1'b1));
		endcase
	endtask

	// driver: offer the head of the pending queue, hold it until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !taken) begin
				// hold the offered item
			end else begin
				taken <= 1'b0;
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser  <= pending_items[0].mode;
					s_tdata  <= {2'b0, pending_items[0].pz, pending_items[0].py,
						pending_items[0].px, pending_items[0].qidx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_results(pending_items.pop_front());
			taken <= 1'b1;
			n_sent++;
		end
	end

	// receiver readiness: a long hold when asked, else random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_recv && hold_left > 0) begin
				m_tready  <= 1'b0;
				hold_left <= hold_left - 1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = mk(status_t'(m_tuser), int'(m_tdata[5:0]), m_tdata[39:6], m_tlast);
			n_got++;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				errors++;
			end else begin
				want = expected_answers.pop_front();
				if (got.status !== want.status || got.idx !== want.idx ||
						got.sq_dist !== want.sq_dist || got.last !== want.last) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	// watchdog: count cycles with no acceptance on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("watchdog expired with %0d results outstanding", expected_answers.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic reg_write(reg_sel_t r, logic [63:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 5'(r) << 3; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (r)
			REG_CELLS:  side_reg = v[4:0];
			REG_CUTOFF: cut_reg  = v[33:0];
			default:    wrap_reg = v[0];
		endcase
	endtask

	task automatic push_item(mode_t m, int q, int x, int y, int z);
		cmd_item_t it;
		it.mode = m; it.qidx = 6'(q);
		it.px = 16'(x); it.py = 16'(y); it.pz = 16'(z);
		pending_items = {pending_items, it};
	endtask

	// wait for the block to drain: queue empty, then its longest latency
	task automatic settle();
		while (pending_items.size() != 0 || s_tvalid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	// clustered positions give many neighbours, plain random adds spread
	task automatic random_phase(int n);
		int m, cx, cy, cz;
		cx = $urandom; cy = $urandom; cz = $urandom;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(99);
			if (m < 3)       push_item(MODE_CLEAR, 0, 0, 0, 0);
			else if (m < 5)  push_item(MODE_BAD, $urandom, $urandom, $urandom, $urandom);
			else if (m < 50) begin
				if ($urandom_range(1))
					push_item(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
				else
					push_item(MODE_LOAD, $urandom, cx + $urandom_range(8000),
						cy + $urandom_range(8000), cz + $urandom_range(8000));
			end else
				push_item(MODE_QUERY, $urandom_range(n_stored + 3), $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
		side_reg = 5'd1; cut_reg = '0; wrap_reg = 1'b0;
		foreach (heads[i]) heads[i] = '0;
		foreach (links[i]) links[i] = '0;
		n_stored = 0; errors = 0; n_sent = 0; n_got = 0; n_queries = 0; n_hits = 0;
		quiet_cycles = 0; hold_recv = 0; hold_left = 0; taken = 0;
		send_idle_pct = 19; recv_idle_pct = 65;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (4200) @(posedge clk);

		// directed: edges of positions, every mode, miss, undefined mode
		reg_write(REG_CELLS, 64'd4);
		reg_write(REG_CUTOFF, 64'h3_FFFF_FFFF);
		reg_write(REG_PERIODIC, 64'd1);
		push_item(MODE_QUERY, 0, 0, 0, 0);
		push_item(MODE_LOAD, 63, 0, 0, 0);
		push_item(MODE_LOAD, 0, 65535, 65535, 65535);
		push_item(MODE_LOAD, 0, 32768, 16384, 49152);
		push_item(MODE_LOAD, 0, 100, 65000, 300);
		push_item(MODE_QUERY, 0, 0, 0, 0);
		push_item(MODE_QUERY, 3, 0, 0, 0);
		push_item(MODE_QUERY, 63, 0, 0, 0);
		push_item(MODE_BAD, 63, 65535, 65535, 65535);
		settle();
		// cell count changed without a clear
		reg_write(REG_CELLS, 64'd16);
		reg_write(REG_PERIODIC, 64'd0);
		push_item(MODE_QUERY, 1, 0, 0, 0);
		push_item(MODE_QUERY, 2, 0, 0, 0);
		push_item(MODE_CLEAR, 0, 0, 0, 0);
		// fill the store and overflow it
		for (int i = 0; i < 65; i++)
			push_item(MODE_LOAD, 0, $urandom, $urandom, $urandom);
		push_item(MODE_QUERY, 63, 0, 0, 0);
		push_item(MODE_CLEAR, 0, 0, 0, 0);
		settle();

		// random phase one, with a long receiver hold so the block fills up
		reg_write(REG_CELLS, 64'd3);
		reg_write(REG_CUTOFF, 64'd400000000);
		hold_left = 300; hold_recv = 1'b1;
		random_phase(30);
		settle();
		hold_recv = 1'b0;

		// random phase two, idling swapped, side 0 counts as one cell
		send_idle_pct = 65; recv_idle_pct = 19;
		reg_write(REG_CELLS, 64'd0);
		reg_write(REG_CUTOFF, 64'd0);
		reg_write(REG_PERIODIC, 64'd1);
		random_phase(15);
		settle();
		reg_write(REG_CELLS, 64'd31);
		reg_write(REG_CUTOFF, 64'd60000000);
		random_phase(20);
		settle();

		// random phase three, no idling
		send_idle_pct = 0; recv_idle_pct = 0;
		reg_write(REG_CELLS, 64'd2);
		reg_write(REG_CUTOFF, 64'd900000000);
		reg_write(REG_PERIODIC, 64'd0);
		random_phase(26);
		settle();

		$display("covered %0d items, %0d results, %0d queries with %0d neighbours",
			n_sent, n_got, n_queries, n_hits);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule
